// File: hw/rtl/i2cme_pkg.sv
// Shared types and constants of the I2C master byte engine.
package i2cme_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned IDX_W  = 2;

	// command codes carried in the cmd field
	localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_START = 3'd1;
	localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ACK   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

	// register indexes on the write port
	localparam logic [IDX_W-1:0] REG_LONG_WAIT  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SHORT_WAIT = 2'd1;
	localparam logic [IDX_W-1:0] REG_ACK_TMO    = 2'd2;

	localparam logic [BYTE_W-1:0] LONG_WAIT_RST  = 8'd2;
	localparam logic [BYTE_W-1:0] SHORT_WAIT_RST = 8'd1;
	localparam logic [BYTE_W-1:0] ACK_TMO_RST    = 8'd250;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [BYTE_W-1:0] tx_byte;
		logic              send_ack;
		logic              sda_sample;
	} cmd_word_t;

	typedef struct packed {
		logic              scl_level;
		logic              sda_level;
		logic              sda_is_output;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] rx_byte;
		logic              ack_failed;
	} res_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0] long_wait_ticks;
		logic [BYTE_W-1:0] short_wait_ticks;
		logic [BYTE_W-1:0] ack_timeout_ticks;
	} cfg_t;

endpackage

// File: hw/rtl/i2cme_cfg.sv
// Timing register file written through the plain configuration port.
module i2cme_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [i2cme_pkg::IDX_W-1:0]     wr_index,
	input  logic [i2cme_pkg::BYTE_W-1:0]    wr_data,
	output i2cme_pkg::cfg_t                 cfg
);

	i2cme_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_wait_ticks   <= i2cme_pkg::LONG_WAIT_RST;
			cfg_q.short_wait_ticks  <= i2cme_pkg::SHORT_WAIT_RST;
			cfg_q.ack_timeout_ticks <= i2cme_pkg::ACK_TMO_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				i2cme_pkg::REG_LONG_WAIT:  cfg_q.long_wait_ticks   <= wr_data;
				i2cme_pkg::REG_SHORT_WAIT: cfg_q.short_wait_ticks  <= wr_data;
				i2cme_pkg::REG_ACK_TMO:    cfg_q.ack_timeout_ticks <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/i2cme_seq.sv
// Bus sequencer: state registers and the per-tick next-state and result logic.
module i2cme_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  i2cme_pkg::cmd_word_t  word,
	input  i2cme_pkg::cfg_t       cfg,
	output i2cme_pkg::res_word_t  res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_S1, PH_S2, PH_P1, PH_P2, PH_W1, PH_W2,
		PH_A1, PH_A2, PH_R1, PH_R2, PH_K1, PH_K2
	} phase_t;

	localparam int unsigned BW = i2cme_pkg::BYTE_W;

	phase_t        phase_q, phase_d;
	logic [3:0]    bit_cnt_q, bit_cnt_d, bit_cnt_inc;
	logic [BW-1:0] shift_q, shift_d;
	logic [BW-1:0] wait_q, wait_d;
	logic [BW-1:0] poll_q, poll_d;
	logic          scl_q, scl_d, sda_q, sda_d, dir_q, dir_d;
	logic          ack_rd_q, ack_rd_d, ack_fail_q, ack_fail_d;
	logic [BW-1:0] rx_hold_q, rx_hold_d;
	logic          ack_choice_q, ack_choice_d;
	logic          done;

	assign bit_cnt_inc = bit_cnt_q + 4'd1;

	always_comb begin
		phase_d      = phase_q;
		bit_cnt_d    = bit_cnt_q;
		shift_d      = shift_q;
		wait_d       = wait_q;
		poll_d       = poll_q;
		scl_d        = scl_q;
		sda_d        = sda_q;
		dir_d        = dir_q;
		ack_rd_d     = ack_rd_q;
		ack_fail_d   = ack_fail_q;
		rx_hold_d    = rx_hold_q;
		ack_choice_d = ack_choice_q;
		done         = 1'b0;

		if (phase_q == PH_IDLE) begin
			case (word.cmd)
				i2cme_pkg::CMD_START: begin
					dir_d   = 1'b1;
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					wait_d  = cfg.long_wait_ticks;
					phase_d = PH_S1;
				end
				i2cme_pkg::CMD_STOP: begin
					ack_rd_d = 1'b0;
					dir_d    = 1'b1;
					scl_d    = 1'b0;
					sda_d    = 1'b0;
					wait_d   = cfg.short_wait_ticks;
					phase_d  = PH_P1;
				end
				i2cme_pkg::CMD_WRITE: begin
					// first bit goes out on the same tick
					dir_d     = 1'b1;
					scl_d     = 1'b0;
					bit_cnt_d = '0;
					sda_d     = word.tx_byte[BW-1];
					shift_d   = {word.tx_byte[BW-2:0], 1'b0};
					wait_d    = cfg.long_wait_ticks;
					phase_d   = PH_W1;
				end
				i2cme_pkg::CMD_ACK: begin
					ack_fail_d = 1'b0;
					poll_d     = '0;
					dir_d      = 1'b0;
					sda_d      = 1'b1;
					wait_d     = cfg.short_wait_ticks;
					phase_d    = PH_A1;
				end
				i2cme_pkg::CMD_READ: begin
					ack_choice_d = word.send_ack;
					bit_cnt_d    = '0;
					shift_d      = '0;
					dir_d        = 1'b0;
					sda_d        = 1'b1;
					scl_d        = 1'b0;
					wait_d       = cfg.long_wait_ticks;
					phase_d      = PH_R1;
				end
				default: ;
			endcase
		end else if (wait_q != '0) begin
			wait_d = wait_q - 1'b1;
		end else begin
			unique case (phase_q)
				PH_S1: begin
					sda_d   = 1'b0;
					wait_d  = cfg.short_wait_ticks;
					phase_d = PH_S2;
				end
				PH_S2: begin
					scl_d   = 1'b0;
					phase_d = PH_IDLE;
					done    = 1'b1;
				end
				PH_P1: begin
					scl_d   = 1'b1;
					wait_d  = cfg.short_wait_ticks;
					phase_d = PH_P2;
				end
				PH_P2: begin
					sda_d   = 1'b1;
					phase_d = PH_IDLE;
					done    = 1'b1;
					// a stop that closes a failed ack wait reports the failure now
					if (ack_rd_q) begin
						ack_fail_d = 1'b1;
						ack_rd_d   = 1'b0;
					end
				end
				PH_W1: begin
					scl_d   = 1'b1;
					wait_d  = cfg.short_wait_ticks;
					phase_d = PH_W2;
				end
				PH_W2: begin
					scl_d     = 1'b0;
					bit_cnt_d = bit_cnt_inc;
					if (bit_cnt_inc >= 4'd8) begin
						phase_d = PH_IDLE;
						done    = 1'b1;
					end else begin
						sda_d   = shift_q[BW-1];
						shift_d = {shift_q[BW-2:0], 1'b0};
						wait_d  = cfg.long_wait_ticks;
						phase_d = PH_W1;
					end
				end
				PH_A1: begin
					scl_d   = 1'b1;
					wait_d  = cfg.short_wait_ticks;
					phase_d = PH_A2;
				end
				PH_A2: begin
					if (!word.sda_sample) begin
						scl_d   = 1'b0;
						phase_d = PH_IDLE;
						done    = 1'b1;
					end else if (poll_q >= cfg.ack_timeout_ticks) begin
						ack_rd_d = 1'b1;
						dir_d    = 1'b1;
						scl_d    = 1'b0;
						sda_d    = 1'b0;
						wait_d   = cfg.short_wait_ticks;
						phase_d  = PH_P1;
					end else begin
						poll_d = poll_q + 1'b1;
					end
				end
				PH_R1: begin
					scl_d   = 1'b1;
					shift_d = {shift_q[BW-2:0], word.sda_sample};
					wait_d  = cfg.short_wait_ticks;
					phase_d = PH_R2;
				end
				PH_R2: begin
					scl_d     = 1'b0;
					bit_cnt_d = bit_cnt_inc;
					wait_d    = cfg.long_wait_ticks;
					if (bit_cnt_inc >= 4'd8) begin
						dir_d   = 1'b1;
						sda_d   = !ack_choice_q;
						phase_d = PH_K1;
					end else begin
						phase_d = PH_R1;
					end
				end
				PH_K1: begin
					scl_d   = 1'b1;
					wait_d  = cfg.long_wait_ticks;
					phase_d = PH_K2;
				end
				PH_K2: begin
					scl_d     = 1'b0;
					rx_hold_d = shift_q;
					phase_d   = PH_IDLE;
					done      = 1'b1;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_cnt_q    <= '0;
			shift_q      <= '0;
			wait_q       <= '0;
			poll_q       <= '0;
			scl_q        <= 1'b1;
			sda_q        <= 1'b1;
			dir_q        <= 1'b1;
			ack_rd_q     <= 1'b0;
			ack_fail_q   <= 1'b0;
			rx_hold_q    <= '0;
			ack_choice_q <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_d;
			bit_cnt_q    <= bit_cnt_d;
			shift_q      <= shift_d;
			wait_q       <= wait_d;
			poll_q       <= poll_d;
			scl_q        <= scl_d;
			sda_q        <= sda_d;
			dir_q        <= dir_d;
			ack_rd_q     <= ack_rd_d;
			ack_fail_q   <= ack_fail_d;
			rx_hold_q    <= rx_hold_d;
			ack_choice_q <= ack_choice_d;
		end
	end

	always_comb begin
		res.scl_level     = scl_d;
		res.sda_level     = sda_d;
		res.sda_is_output = dir_d;
		res.busy_res      = (phase_d != PH_IDLE);
		res.done_res      = done;
		res.rx_byte       = rx_hold_d;
		res.ack_failed    = ack_fail_d;
	end

endmodule

// File: hw/rtl/i2cme_oreg.sv
// Result register with a skid stage so the input-side space flag comes from a register, not from res_ready.
module i2cme_oreg (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  i2cme_pkg::res_word_t  push_word,
	output logic                  space,
	output logic                  res_valid,
	input  logic                  res_ready,
	output i2cme_pkg::res_word_t  res_word
);

	logic                 main_valid_q, skid_valid_q;
	i2cme_pkg::res_word_t main_q, skid_q;
	logic                 main_free;

	assign main_free = !main_valid_q || res_ready;
	assign space     = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			// drain the skid entry first to keep order
			main_q <= skid_valid_q ? skid_q : push_word;
		end else if (push) begin
			skid_q <= push_word;
		end
	end

	assign res_valid = main_valid_q;
	assign res_word  = main_q;

endmodule

// File: hw/rtl/i2c_master_byte_engine_core.sv
// An accepted tick word's result is registered into the main entry, or into the skid entry while main is held.
// Throughput: one tick word per cycle while the skid entry is free; the sequencer advances in a single pass.
// A two-entry result register (main plus skid) keeps cmd_ready off res_ready.
// Reset (arst_n low, asynchronous): SCL and SDA high, SDA driven, idle, no result.
// Timing registers reset to long 2, short 1, ack timeout 250.
module i2c_master_byte_engine_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  i2cme_pkg::cmd_word_t          cmd_word,
	output logic                          res_valid,
	input  logic                          res_ready,
	output i2cme_pkg::res_word_t          res_word,
	input  logic                          wr_en,
	input  logic [i2cme_pkg::IDX_W-1:0]   wr_index,
	input  logic [i2cme_pkg::BYTE_W-1:0]  wr_data
);

	i2cme_pkg::cfg_t      cfg;
	i2cme_pkg::res_word_t next_res;
	logic                 step;

	assign step = cmd_valid && cmd_ready;

	i2cme_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	i2cme_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.word   (cmd_word),
		.cfg    (cfg),
		.res    (next_res)
	);

	i2cme_oreg u_oreg (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (step),
		.push_word (next_res),
		.space     (cmd_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

// File: hw/rtl/i2cme_chk.sv
// Port-level checker for the I2C master byte engine, bound to the top level.
module i2cme_chk (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cmd_ready,
	input logic                  res_valid,
	input logic                  res_ready,
	input i2cme_pkg::res_word_t  res_word
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	// a word that reports completion is never still busy
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_word.done_res && res_word.busy_res))
		else $error("done and busy in the same word");

	// released SDA always carries a high latch
	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.sda_is_output |-> res_word.sda_level)
		else $error("SDA released with low latch");

	// input stalls only when both result entries are full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid)
		else $error("input stalled with empty result register");

endmodule

bind i2c_master_byte_engine_core i2cme_chk u_i2cme_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_ready (cmd_ready),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res_word  (res_word)
);
